@@ rtl/core/iarc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iarc_pkg: shared types and constants for the IMU accel/rate conditioner
// Sequencer states, filter selection, control bundle and register indexes.
// ----------------------------------------------------------------------------
package iarc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_GRAVITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LINEAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RATE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_GRAVITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LINEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_RATE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 3'd6;

    localparam logic [1:0] AXIS_FIRST = 2'd0;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        FILT_GRAV,
        FILT_LIN,
        FILT_RATE
    } t_filt;

    typedef struct packed {
        logic       idle;
        logic       mul_en;
        logic       acc_en;
        logic       done;
        t_filt      filt;
        logic [1:0] axis;
    } t_ctrl;

endpackage

@@ rtl/core/iarc_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iarc_seq: step sequencer
// Walks nine multiply/accumulate steps (three filters by three axes) per
// request, then waits for the output register to take the result.
// ----------------------------------------------------------------------------
module iarc_seq
    import iarc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    output t_ctrl o_ctrl
);

    t_state     r_state, n_state;
    t_filt      r_filt, n_filt;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_filt  <= FILT_GRAV;
            r_axis  <= AXIS_FIRST;
        end else begin
            r_state <= n_state;
            r_filt  <= n_filt;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_filt  = r_filt;
        n_axis  = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                n_filt = FILT_GRAV;
                n_axis = AXIS_FIRST;
                if (i_start) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_axis == AXIS_LAST) begin
                    n_axis = AXIS_FIRST;
                    unique case (r_filt)
                        FILT_GRAV: begin
                            n_filt  = FILT_LIN;
                            n_state = ST_MUL;
                        end
                        FILT_LIN: begin
                            n_filt  = FILT_RATE;
                            n_state = ST_MUL;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.filt   = r_filt;
        o_ctrl.axis   = r_axis;
        unique case (r_state)
            ST_IDLE: o_ctrl.idle   = 1'b1;
            ST_MUL:  o_ctrl.mul_en = 1'b1;
            ST_ACC:  o_ctrl.acc_en = 1'b1;
            ST_DONE: o_ctrl.done   = i_out_free;
            default: o_ctrl.idle   = 1'b0;
        endcase
    end

endmodule

@@ rtl/core/iarc_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iarc_mac: shared filter unit
// One multiplier step per filter axis: held + (w * (x - held)) >>> FRAC,
// then pass-through, symmetric clamp and, for linear accel, deadband.
// ----------------------------------------------------------------------------
module iarc_mac
    import iarc_pkg::*;
#(
    parameter int SAMPLE_BITS      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  t_ctrl                         i_ctrl,
    input  logic [WEIGHT_FRAC_BITS:0]     i_weight,
    input  logic [SAMPLE_BITS-2:0]        i_clamp,
    input  logic [SAMPLE_BITS-2:0]        i_dead_zone,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_h,
    input  logic                          i_pass,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int SB = SAMPLE_BITS;
    localparam int FB = WEIGHT_FRAC_BITS;
    localparam int PW = SB + FB + 3;

    logic [FB:0]            w_sat;
    logic signed [FB+1:0]   w_ext;
    logic signed [SB:0]     d;
    logic signed [PW-1:0]   n_p;

    logic signed [PW-1:0]   r_p;
    logic signed [SB-1:0]   r_x;
    logic signed [SB-1:0]   r_h;
    logic                   r_pass;

    logic signed [SB+1:0]   sum;
    logic signed [SB-1:0]   f;
    logic signed [SB-1:0]   lim_p;
    logic signed [SB-1:0]   lim_n;
    logic signed [SB-1:0]   dz_p;
    logic signed [SB-1:0]   dz_n;
    logic signed [SB-1:0]   c;

    always_comb begin
        w_sat = i_weight[FB] ? {1'b1, {FB{1'b0}}} : i_weight;
        w_ext = signed'({1'b0, w_sat});
        d     = {i_x[SB-1], i_x} - {i_h[SB-1], i_h};
        n_p   = PW'(w_ext) * PW'(d);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_p    <= n_p;
            r_x    <= i_x;
            r_h    <= i_h;
            r_pass <= i_pass;
        end
    end

    always_comb begin
        sum   = (SB+2)'(r_p >>> FB) + (SB+2)'(r_h);
        f     = r_pass ? r_x : sum[SB-1:0];
        lim_p = signed'({1'b0, i_clamp});
        lim_n = -lim_p;
        dz_p  = signed'({1'b0, i_dead_zone});
        dz_n  = -dz_p;
        priority if (f > lim_p) begin
            c = lim_p;
        end else if (f < lim_n) begin
            c = lim_n;
        end else begin
            c = f;
        end
        if (i_ctrl.filt == FILT_LIN) begin
            priority if (c > dz_p) begin
                o_result = c - dz_p;
            end else if (c < dz_n) begin
                o_result = c + dz_p;
            end else begin
                o_result = '0;
            end
        end else begin
            o_result = c;
        end
    end

endmodule

@@ rtl/core/imu_accel_rate_conditioner_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_accel_rate_conditioner_unit: IMU acceleration and rate conditioner
// Sequence: 9 steps on the one shared multiplier, each a multiply state then an
//   accumulate state, then a load into the output register.
// A new request is taken only once the sequencer is back in idle; output stalls delay that.
// Reset: synchronous active low; filter state clears to zero, registers load
//   their defaults, output register empties.
// ----------------------------------------------------------------------------
module imu_accel_rate_conditioner_unit
    import iarc_pkg::*;
#(
    parameter int SAMPLE_BITS      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [((WEIGHT_FRAC_BITS + 1 > SAMPLE_BITS - 1) ?
                   WEIGHT_FRAC_BITS + 1 : SAMPLE_BITS - 1)-1:0] i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SAMPLE_BITS-1:0]  i_raw_acc_x,
    input  logic [SAMPLE_BITS-1:0]  i_raw_acc_y,
    input  logic [SAMPLE_BITS-1:0]  i_raw_acc_z,
    input  logic [SAMPLE_BITS-1:0]  i_raw_rate_x,
    input  logic [SAMPLE_BITS-1:0]  i_raw_rate_y,
    input  logic [SAMPLE_BITS-1:0]  i_raw_rate_z,
    input  logic [SAMPLE_BITS-1:0]  i_grav_est_x,
    input  logic [SAMPLE_BITS-1:0]  i_grav_est_y,
    input  logic [SAMPLE_BITS-1:0]  i_grav_est_z,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SAMPLE_BITS-1:0]  o_out_acc_x,
    output logic [SAMPLE_BITS-1:0]  o_out_acc_y,
    output logic [SAMPLE_BITS-1:0]  o_out_acc_z,
    output logic [SAMPLE_BITS-1:0]  o_out_rate_x,
    output logic [SAMPLE_BITS-1:0]  o_out_rate_y,
    output logic [SAMPLE_BITS-1:0]  o_out_rate_z
);

    localparam int SB  = SAMPLE_BITS;
    localparam int FB  = WEIGHT_FRAC_BITS;
    localparam int QFB = SB - 6;

    localparam logic [63:0] W_ONE    = 64'd1 << FB;
    localparam logic [63:0] Q_ONE    = 64'd1 << QFB;
    localparam logic [63:0] RST_WG   = (64'd3 * W_ONE + 64'd5) / 64'd10;
    localparam logic [63:0] RST_WL   = (W_ONE + 64'd10) / 64'd20;
    localparam logic [63:0] RST_WR   = W_ONE >> 1;
    localparam logic [63:0] RST_CG   = (64'd1081 * Q_ONE + 64'd50) / 64'd100;
    localparam logic [63:0] RST_CL   = Q_ONE;
    localparam logic [63:0] RST_DZ   = (Q_ONE + 64'd50) / 64'd100;

    t_ctrl ctrl;
    logic  in_acc;
    logic  out_free;

    logic [FB:0]   r_w_grav, r_w_lin, r_w_rate;
    logic [SB-2:0] r_c_grav, r_c_lin, r_c_rate, r_dead_zone;

    logic signed [SB-1:0] r_acc  [3];
    logic signed [SB-1:0] r_rate [3];
    logic signed [SB-1:0] r_grav [3];
    logic signed [SB-1:0] r_held_grav [3];
    logic signed [SB-1:0] r_held_lin  [3];
    logic signed [SB-1:0] r_held_rate [3];
    logic [2:0]           r_pass;

    logic                 r_out_valid;
    logic signed [SB-1:0] r_out_acc  [3];
    logic signed [SB-1:0] r_out_rate [3];

    logic signed [SB-1:0] hg_sel;
    logic signed [SB-1:0] gr_sel;
    logic signed [SB:0]   diff_w;
    logic signed [SB-1:0] diff_sat;

    logic [FB:0]          mac_w;
    logic [SB-2:0]        mac_lim;
    logic signed [SB-1:0] mac_x;
    logic signed [SB-1:0] mac_h;
    logic                 mac_pass;
    logic signed [SB-1:0] mac_y;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = !ctrl.idle;
    assign out_free   = !r_out_valid || !i_out_stall;

    iarc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_grav    <= RST_WG[FB:0];
            r_w_lin     <= RST_WL[FB:0];
            r_w_rate    <= RST_WR[FB:0];
            r_c_grav    <= RST_CG[SB-2:0];
            r_c_lin     <= RST_CL[SB-2:0];
            r_c_rate    <= RST_CL[SB-2:0];
            r_dead_zone <= RST_DZ[SB-2:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WEIGHT_GRAVITY: r_w_grav    <= i_cfg_data[FB:0];
                CFG_WEIGHT_LINEAR:  r_w_lin     <= i_cfg_data[FB:0];
                CFG_WEIGHT_RATE:    r_w_rate    <= i_cfg_data[FB:0];
                CFG_CLAMP_GRAVITY:  r_c_grav    <= i_cfg_data[SB-2:0];
                CFG_CLAMP_LINEAR:   r_c_lin     <= i_cfg_data[SB-2:0];
                CFG_CLAMP_RATE:     r_c_rate    <= i_cfg_data[SB-2:0];
                CFG_DEAD_ZONE:      r_dead_zone <= i_cfg_data[SB-2:0];
                default: ;
            endcase
        end
    end

    // capture request and pass-through flags from state before update
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_acc[0]  <= i_raw_acc_x;
            r_acc[1]  <= i_raw_acc_y;
            r_acc[2]  <= i_raw_acc_z;
            r_rate[0] <= i_raw_rate_x;
            r_rate[1] <= i_raw_rate_y;
            r_rate[2] <= i_raw_rate_z;
            r_grav[0] <= i_grav_est_x;
            r_grav[1] <= i_grav_est_y;
            r_grav[2] <= i_grav_est_z;
            r_pass[0] <= (r_held_grav[0] == '0) && (r_held_grav[1] == '0)
                         && (r_held_grav[2] == '0);
            r_pass[1] <= (r_held_lin[0] == '0) && (r_held_lin[1] == '0)
                         && (r_held_lin[2] == '0);
            r_pass[2] <= (r_held_rate[0] == '0) && (r_held_rate[1] == '0)
                         && (r_held_rate[2] == '0);
        end
    end

    always_comb begin
        hg_sel = r_held_grav[ctrl.axis];
        gr_sel = r_grav[ctrl.axis];
        diff_w = {hg_sel[SB-1], hg_sel} - {gr_sel[SB-1], gr_sel};
        if (diff_w[SB] != diff_w[SB-1]) begin
            diff_sat = diff_w[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
            diff_sat = diff_w[SB-1:0];
        end
    end

    always_comb begin
        unique case (ctrl.filt)
            FILT_GRAV: begin
                mac_w    = r_w_grav;
                mac_lim  = r_c_grav;
                mac_x    = r_acc[ctrl.axis];
                mac_h    = hg_sel;
                mac_pass = r_pass[0];
            end
            FILT_LIN: begin
                mac_w    = r_w_lin;
                mac_lim  = r_c_lin;
                mac_x    = diff_sat;
                mac_h    = r_held_lin[ctrl.axis];
                mac_pass = r_pass[1];
            end
            default: begin
                mac_w    = r_w_rate;
                mac_lim  = r_c_rate;
                mac_x    = r_rate[ctrl.axis];
                mac_h    = r_held_rate[ctrl.axis];
                mac_pass = r_pass[2];
            end
        endcase
    end

    iarc_mac #(
        .SAMPLE_BITS      (SB),
        .WEIGHT_FRAC_BITS (FB)
    ) u_mac (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_weight    (mac_w),
        .i_clamp     (mac_lim),
        .i_dead_zone (r_dead_zone),
        .i_x         (mac_x),
        .i_h         (mac_h),
        .i_pass      (mac_pass),
        .o_result    (mac_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_held_grav[i] <= '0;
                r_held_lin[i]  <= '0;
                r_held_rate[i] <= '0;
            end
        end else if (ctrl.acc_en) begin
            unique case (ctrl.filt)
                FILT_GRAV: r_held_grav[ctrl.axis] <= mac_y;
                FILT_LIN:  r_held_lin[ctrl.axis]  <= mac_y;
                default:   r_held_rate[ctrl.axis] <= mac_y;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.done) begin
            for (int i = 0; i < 3; i++) begin
                r_out_acc[i]  <= r_held_lin[i];
                r_out_rate[i] <= r_held_rate[i];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_acc_x  = r_out_acc[0];
    assign o_out_acc_y  = r_out_acc[1];
    assign o_out_acc_z  = r_out_acc[2];
    assign o_out_rate_x = r_out_rate[0];
    assign o_out_rate_y = r_out_rate[1];
    assign o_out_rate_z = r_out_rate[2];

    a_busy_after_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall
    ) else $error("request accepted while sequencer not idle afterwards");

    a_out_load_from_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(ctrl.done)
    ) else $error("output valid raised without a finished request");

    a_state_hold_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.idle && !in_acc) |=> ($stable(r_held_grav[0]) && $stable(r_held_lin[0])
                                    && $stable(r_held_rate[2]))
    ) else $error("filter state changed while idle");

endmodule
